// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes of the double-ended queue with half rotation.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // action codes
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_ROTATE     = 3'd4;

  // status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_VALID = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
  } rsp_t;

  // result handed from the controller to the output register
  typedef struct packed {
    logic valid;
    rsp_t item;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_ROT
  } deq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Ring store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic signed [31:0] wdata,
  input  wire logic               re,
  input  wire logic [AW-1:0]      raddr,
  output logic signed [31:0]      rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Front index, count and sequencer: pushes, pops and the half rotation,
// which moves the first count/2 items one by one behind the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int CW    = 11
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire deq_pkg::cmd_t      cmd,
  input  wire logic               res_free,
  output logic                    cmd_stall,
  output deq_pkg::result_t        res,
  output logic                    ren,
  output logic [AW-1:0]           raddr,
  input  wire logic signed [31:0] rdata,
  output logic                    we,
  output logic [AW-1:0]           waddr,
  output logic signed [31:0]      wdata
);

  deq_pkg::deq_state_t state, state_next;
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [CW-1:0] rot_left, rot_left_next;
  logic          rd_pend, rd_pend_next;

  logic          take;
  logic          full;
  logic          empty;
  logic [AW-1:0] cnt_lo;
  logic [AW-1:0] tail;
  logic [AW-1:0] back;

  function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  assign cmd_stall = !((state == deq_pkg::S_IDLE) && res_free);
  assign take      = cmd_valid && !cmd_stall;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign cnt_lo    = count[AW-1:0];
  // when full the slot behind the tail is the front itself
  assign tail      = full ? front : add_wrap(front, cnt_lo);
  assign back      = add_wrap(front, cnt_lo - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= deq_pkg::S_IDLE;
      front    <= '0;
      count    <= '0;
      rd_pend  <= 1'b0;
      rot_left <= '0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      count    <= count_next;
      rd_pend  <= rd_pend_next;
      rot_left <= rot_left_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    wr_ptr <= wr_ptr_next;
  end

  always_comb begin
    state_next    = state;
    front_next    = front;
    count_next    = count;
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    rot_left_next = rot_left;
    rd_pend_next  = 1'b0;
    ren           = 1'b0;
    raddr         = front;
    we            = 1'b0;
    waddr         = tail;
    wdata         = cmd.value;
    res           = '0;

    case (state)
      deq_pkg::S_IDLE: begin
        if (take) begin
          case (cmd.action)
            deq_pkg::ACT_PUSH_FRONT: begin
              res.valid = 1'b1;
              if (full) begin
                res.item.status = deq_pkg::STAT_FULL;
              end else begin
                we         = 1'b1;
                waddr      = dec_wrap(front);
                front_next = dec_wrap(front);
                count_next = count + 1'b1;
              end
            end
            deq_pkg::ACT_PUSH_BACK: begin
              res.valid = 1'b1;
              if (full) begin
                res.item.status = deq_pkg::STAT_FULL;
              end else begin
                we         = 1'b1;
                waddr      = tail;
                count_next = count + 1'b1;
              end
            end
            deq_pkg::ACT_POP_FRONT: begin
              if (empty) begin
                res.valid       = 1'b1;
                res.item.status = deq_pkg::STAT_EMPTY;
              end else begin
                ren        = 1'b1;
                raddr      = front;
                front_next = inc_wrap(front);
                count_next = count - 1'b1;
                state_next = deq_pkg::S_POP_WAIT;
              end
            end
            deq_pkg::ACT_POP_BACK: begin
              if (empty) begin
                res.valid       = 1'b1;
                res.item.status = deq_pkg::STAT_EMPTY;
              end else begin
                ren        = 1'b1;
                raddr      = back;
                count_next = count - 1'b1;
                state_next = deq_pkg::S_POP_WAIT;
              end
            end
            deq_pkg::ACT_ROTATE: begin
              if (count < CW'(2)) begin
                res.valid = 1'b1;
              end else begin
                rd_ptr_next   = front;
                wr_ptr_next   = tail;
                rot_left_next = count >> 1;
                state_next    = deq_pkg::S_ROT;
              end
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      deq_pkg::S_POP_WAIT: begin
        res.valid             = 1'b1;
        res.item.status       = deq_pkg::STAT_VALID;
        res.item.popped_value = rdata;
        state_next            = deq_pkg::S_IDLE;
      end
      deq_pkg::S_ROT: begin
        // read the next head item while the previous one lands behind the tail
        if (rot_left != '0) begin
          ren           = 1'b1;
          raddr         = rd_ptr;
          rd_ptr_next   = inc_wrap(rd_ptr);
          rot_left_next = rot_left - 1'b1;
          rd_pend_next  = 1'b1;
        end
        if (rd_pend) begin
          we          = 1'b1;
          waddr       = wr_ptr;
          wdata       = rdata;
          wr_ptr_next = inc_wrap(wr_ptr);
        end
        if ((rot_left == '0) && !rd_pend) begin
          front_next = rd_ptr;
          res.valid  = 1'b1;
          state_next = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/deque_with_half_rotation_unit.sv =====
// ----------------------------------------------------------------------------
// deque_with_half_rotation_unit
// Double-ended queue of signed 32-bit values in a ring memory, with push and
// pop at both ends and a rotation that brings the middle item to the front.
//
//   channel  signals                     payload
//   cmd      cmd_valid / cmd_stall       cmd (action, value)
//   rsp      rsp_valid / rsp_stall       rsp (status, popped_value)
//
// Push, empty pop, short rotation and unknown actions end in the cycle they
// are taken. Pop: the value is the registered read data of the ring memory.
// Rotation of n >= 2 items moves the first n/2 behind the tail, one item per
// cycle over the single read port and single write port of the ring memory.
// Reset clears the indices only; the memory needs no clearing pass.
// A new item is taken only when the output register is empty or drains.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_half_rotation_unit #(
  parameter int DEPTH = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire deq_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output deq_pkg::rsp_t      rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  deq_pkg::result_t   ctrl_res;
  logic               res_free;
  logic               ren;
  logic               we;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic signed [31:0] rdata;
  logic signed [31:0] wdata;
  logic               cmd_take;

  assign res_free = !rsp_valid || !rsp_stall;
  assign cmd_take = cmd_valid && !cmd_stall;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .res_free  (res_free),
    .cmd_stall (cmd_stall),
    .res       (ctrl_res),
    .ren       (ren),
    .raddr     (raddr),
    .rdata     (rdata),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata)
  );

  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl_res.valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_res.valid) begin
      rsp <= ctrl_res.item;
    end
  end

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl_res.valid |-> res_free)
    else $error("result produced while output register is blocked");

  // pushes and unknown actions finish in the cycle they are taken
  a_push_one_cycle: assert property (@(posedge clk) disable iff (rst)
    cmd_take && (cmd.action == deq_pkg::ACT_PUSH_FRONT ||
                 cmd.action == deq_pkg::ACT_PUSH_BACK ||
                 cmd.action > deq_pkg::ACT_ROTATE)
    |-> ctrl_res.valid)
    else $error("push item did not complete in its cycle");

  // popped data comes in the cycle after the item was taken
  a_pop_latency: assert property (@(posedge clk) disable iff (rst)
    ctrl_res.valid && (ctrl_res.item.status == deq_pkg::STAT_VALID) |-> $past(cmd_take))
    else $error("popped value without a pop taken the cycle before");

endmodule

`default_nettype wire
